/* rtl/slxfp_pkg.sv */
// Package for the sync/length/XOR frame parser.
// Holds the sync word, header constants, status codes and parser phase type.
// No dependencies.
package slxfp_pkg;

    localparam int unsigned SYNC_LEN = 4;
    localparam logic [7:0] SYNC_WORD [SYNC_LEN] = '{8'h47, 8'h41, 8'h4D, 8'h45};

    localparam logic [7:0] HDR_BYTES = 8'd5;
    localparam logic [7:0] MIN_LEN   = 8'd6;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_MISMATCH = 3'd1,
        ST_TRUNC    = 3'd2,
        ST_NOHDR    = 3'd3,
        ST_BADLEN   = 3'd4
    } frame_status_t;

    typedef enum logic [3:0] {
        PH_HUNT = 4'b0001,
        PH_LEN  = 4'b0010,
        PH_BODY = 4'b0100,
        PH_DONE = 4'b1000
    } parse_phase_t;

endpackage

/* rtl/sync_length_xor_frame_parser_core.sv */
// Sync/length/XOR frame parser, top level.
// Depends on slxfp_pkg.
// Parses one datagram byte per request into payload and status results.
//
// Each result is held in a single output register and shown in the cycle after its byte is
// accepted. s_ready is high whenever that register is empty or being taken in the same cycle,
// so with m_ready high a stream runs at one byte per cycle. The parser hunts for
// "GAME", reads a length byte that counts the whole frame (sync, length, payload, check byte),
// forwards each payload byte (item_kind 0) and closes the frame with one status result
// (item_kind 1, is_last 1): 0 ok, 1 check mismatch, 2 truncated, 3 no header, 4 bad length.
// Payload goes out before its status, so discard it on any non-zero status. Bytes after the
// frame give no result; the end-of-datagram flag always returns the parser to hunting.
module sync_length_xor_frame_parser_core (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_end_of_datagram,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_item_kind,
    output logic [7:0] m_payload_byte,
    output logic [2:0] m_frame_status,
    output logic       m_is_last
);
    import slxfp_pkg::*;

    parse_phase_t  phase_reg, phase_next;
    logic [1:0]    sync_matched_reg, sync_matched_next;
    logic [7:0]    bytes_left_reg, bytes_left_next;
    logic [7:0]    running_xor_reg, running_xor_next;

    logic          m_valid_reg, m_valid_next;
    logic          item_kind_reg;
    logic [7:0]    payload_byte_reg;
    frame_status_t frame_status_reg;

    logic          s_accept;
    logic          emit;
    logic          emit_kind;
    logic [7:0]    emit_payload;
    frame_status_t emit_status;

    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    always_comb begin
        phase_next        = phase_reg;
        sync_matched_next = sync_matched_reg;
        bytes_left_next   = bytes_left_reg;
        running_xor_next  = running_xor_reg;
        emit              = 1'b0;
        emit_kind         = KIND_STATUS;
        emit_payload      = 8'd0;
        emit_status       = ST_OK;

        case (phase_reg)
            PH_HUNT: begin
                if (s_data_byte == SYNC_WORD[sync_matched_reg]) begin
                    if (sync_matched_reg == 2'(SYNC_LEN - 1)) begin
                        sync_matched_next = 2'd0;
                        phase_next        = PH_LEN;
                    end else begin
                        sync_matched_next = sync_matched_reg + 2'd1;
                    end
                end else begin
                    sync_matched_next = (s_data_byte == SYNC_WORD[0]) ? 2'd1 : 2'd0;
                end
                if (s_end_of_datagram) begin
                    emit        = 1'b1;
                    emit_status = (phase_next == PH_LEN) ? ST_TRUNC : ST_NOHDR;
                end
            end
            PH_LEN: begin
                if (s_data_byte < MIN_LEN) begin
                    emit        = 1'b1;
                    emit_status = ST_BADLEN;
                    phase_next  = PH_DONE;
                end else if (s_end_of_datagram) begin
                    emit        = 1'b1;
                    emit_status = ST_TRUNC;
                end else begin
                    bytes_left_next  = s_data_byte - HDR_BYTES;
                    running_xor_next = 8'd0;
                    phase_next       = PH_BODY;
                end
            end
            PH_BODY: begin
                if (bytes_left_reg <= 8'd1) begin
                    emit            = 1'b1;
                    emit_status     = (s_data_byte == running_xor_reg) ? ST_OK : ST_MISMATCH;
                    phase_next      = PH_DONE;
                    bytes_left_next = 8'd0;
                end else if (s_end_of_datagram) begin
                    emit        = 1'b1;
                    emit_status = ST_TRUNC;
                end else begin
                    running_xor_next = running_xor_reg ^ s_data_byte;
                    bytes_left_next  = bytes_left_reg - 8'd1;
                    emit             = 1'b1;
                    emit_kind        = KIND_PAYLOAD;
                    emit_payload     = s_data_byte;
                end
            end
            default: begin
            end
        endcase

        if (s_end_of_datagram) begin
            phase_next        = PH_HUNT;
            sync_matched_next = 2'd0;
            bytes_left_next   = 8'd0;
            running_xor_next  = 8'd0;
        end
    end

    always_comb begin
        if (s_accept) begin
            m_valid_next = emit;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_HUNT;
            sync_matched_reg <= 2'd0;
            bytes_left_reg   <= 8'd0;
            running_xor_reg  <= 8'd0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (s_accept) begin
                phase_reg        <= phase_next;
                sync_matched_reg <= sync_matched_next;
                bytes_left_reg   <= bytes_left_next;
                running_xor_reg  <= running_xor_next;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && emit) begin
            item_kind_reg    <= emit_kind;
            payload_byte_reg <= emit_payload;
            frame_status_reg <= emit_status;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_item_kind    = item_kind_reg;
    assign m_payload_byte = payload_byte_reg;
    assign m_frame_status = frame_status_reg;
    assign m_is_last      = item_kind_reg;

`ifndef SYNTHESIS
    a_status_ends_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_item_kind == KIND_PAYLOAD) |-> (m_frame_status == ST_OK) && !m_is_last)
        else $error("payload result carries status or last flag");

    a_eod_rehunts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && s_end_of_datagram |=> (phase_reg == PH_HUNT) && (sync_matched_reg == 2'd0))
        else $error("end of datagram did not return parser to hunting");

    a_sync_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg != PH_HUNT) |-> (sync_matched_reg == 2'd0))
        else $error("sync count nonzero outside hunt");

    a_body_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_BODY) |-> (bytes_left_reg != 8'd0))
        else $error("frame body with no bytes left");

    a_one_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(phase_reg))
        else $error("parser phase not one-hot");
`endif

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for sync_length_xor_frame_parser_core: directed and random datagrams.
// The predictor tracks the sync, length and XOR state and matches each result in order.
// Depends on slxfp_pkg and the parser RTL.
module testbench;
    import slxfp_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic          kind;
        logic [7:0]    payload;
        frame_status_t status;
        logic          last;
    } frame_result_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_data_byte = 8'h00;
    logic       s_end_of_datagram = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic       m_item_kind;
    logic [7:0] m_payload_byte;
    logic [2:0] m_frame_status;
    logic       m_is_last;

    frame_result_t frame_results_due[$];
    frame_result_t oldest_due;
    parse_phase_t  parser_phase = PH_HUNT;
    int            sync_count = 0;
    logic [7:0]    frame_left = 8'h00;
    logic [7:0]    payload_xor = 8'h00;

    int idle_pct = 0;
    int stall_pct = 0;
    int bytes_sent = 0;
    int error_count = 0;
    int cycle_count = 0;

    sync_length_xor_frame_parser_core dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_data_byte       (s_data_byte),
        .s_end_of_datagram (s_end_of_datagram),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_item_kind       (m_item_kind),
        .m_payload_byte    (m_payload_byte),
        .m_frame_status    (m_frame_status),
        .m_is_last         (m_is_last)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0h want %0h (cycle %0d)", what, got, want, cycle_count);
        error_count++;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (frame_results_due.size() == 0) begin
                report_mismatch("unexpected result kind", m_item_kind, 0);
            end else begin
                oldest_due = frame_results_due.pop_front();
                if (m_item_kind !== oldest_due.kind)
                    report_mismatch("item_kind", m_item_kind, oldest_due.kind);
                if (m_payload_byte !== oldest_due.payload)
                    report_mismatch("payload_byte", m_payload_byte, oldest_due.payload);
                if (m_frame_status !== oldest_due.status)
                    report_mismatch("frame_status", m_frame_status, oldest_due.status);
                if (m_is_last !== oldest_due.last)
                    report_mismatch("is_last", m_is_last, oldest_due.last);
            end
        end
    end

    function automatic void expect_status(input frame_status_t st);
        frame_results_due.push_back('{KIND_STATUS, 8'h00, st, 1'b1});
    endfunction

    function automatic void parse_byte(input logic [7:0] b, input logic eod);
        case (parser_phase)
            PH_HUNT: begin
                if (b == SYNC_WORD[sync_count]) begin
                    sync_count++;
                    if (sync_count == SYNC_LEN) begin
                        sync_count = 0;
                        parser_phase = PH_LEN;
                    end
                end else begin
                    sync_count = (b == SYNC_WORD[0]) ? 1 : 0;
                end
                if (eod)
                    expect_status(parser_phase == PH_LEN ? ST_TRUNC : ST_NOHDR);
            end
            PH_LEN: begin
                if (b < MIN_LEN) begin
                    expect_status(ST_BADLEN);
                    parser_phase = PH_DONE;
                end else if (eod) begin
                    expect_status(ST_TRUNC);
                end else begin
                    frame_left = b - HDR_BYTES;
                    payload_xor = 8'h00;
                    parser_phase = PH_BODY;
                end
            end
            PH_BODY: begin
                if (frame_left <= 8'd1) begin
                    expect_status(b == payload_xor ? ST_OK : ST_MISMATCH);
                    parser_phase = PH_DONE;
                    frame_left = 8'h00;
                end else if (eod) begin
                    expect_status(ST_TRUNC);
                end else begin
                    payload_xor = payload_xor ^ b;
                    frame_left = frame_left - 8'd1;
                    frame_results_due.push_back('{KIND_PAYLOAD, b, ST_OK, 1'b0});
                end
            end
            default: ;
        endcase
        if (eod) begin
            sync_count = 0;
            parser_phase = PH_HUNT;
            frame_left = 8'h00;
            payload_xor = 8'h00;
        end
    endfunction

    task automatic send_byte(input logic [7:0] data, input logic eod);
        if (idle_pct > 0) begin
            while ($urandom_range(99) < idle_pct) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_data_byte <= data;
        s_end_of_datagram <= eod;
        do @(posedge aclk); while (!s_ready);
        parse_byte(data, eod);
        bytes_sent++;
    endtask

    task automatic send_datagram(input logic [7:0] dg[$]);
        foreach (dg[i])
            send_byte(dg[i], i == dg.size() - 1);
    endtask

    task automatic hold_until_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (frame_results_due.size() != 0);
    endtask

    task automatic send_random_datagram();
        logic [7:0] dg[$];
        logic [7:0] chk;
        logic [7:0] b;
        int pick;
        int flen;
        dg = {};
        pick = $urandom_range(99);
        if (pick < 15) begin
            repeat ($urandom_range(1, 8))
                dg.push_back(($urandom_range(3) == 0) ? SYNC_WORD[$urandom_range(3)] : 8'($urandom));
        end else begin
            repeat ($urandom_range(0, 2))
                dg.push_back(($urandom_range(1) == 0) ? SYNC_WORD[0] : 8'($urandom));
            for (int i = 0; i < SYNC_LEN; i++)
                dg.push_back(SYNC_WORD[i]);
            if ($urandom_range(9) == 0)
                dg[dg.size() - 1 - $urandom_range(3)] = 8'($urandom);
            pick = $urandom_range(99);
            if (pick < 10)
                flen = $urandom_range(0, 5);
            else if (pick < 13)
                flen = 255;
            else if (pick < 18)
                flen = $urandom_range(17, 60);
            else
                flen = $urandom_range(6, 16);
            dg.push_back(8'(flen));
            if (flen >= MIN_LEN) begin
                chk = 8'h00;
                for (int i = 0; i < flen - 6; i++) begin
                    b = 8'($urandom);
                    chk ^= b;
                    dg.push_back(b);
                end
                if ($urandom_range(9) == 0)
                    chk ^= 8'($urandom_range(1, 255));
                dg.push_back(chk);
            end
            repeat ($urandom_range(0, 2))
                dg.push_back(8'($urandom));
            if ($urandom_range(9) == 0) begin
                pick = $urandom_range(1, dg.size());
                while (dg.size() > pick) dg.delete(dg.size() - 1);
            end
        end
        send_datagram(dg);
    endtask

    task automatic random_traffic(input int n_bytes);
        int stop_at;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) send_random_datagram();
    endtask

    task automatic test_directed_cases();
        idle_pct = 0;
        stall_pct = 0;
        // restart on repeated G, shortest legal length, bad check
        send_datagram('{"G", "G", "A", "M", "E", 8'd6, 8'hFF});
        send_datagram('{8'h00});
        // short length, then ignored bytes up to the end
        send_datagram('{"G", "A", "M", "E", 8'd5, 8'hAA});
        send_datagram('{"G", "A", "M", "E"});
        send_datagram('{"G", "A", "M", "E", 8'hFF});
        send_datagram('{"G", "A", "M", "E", 8'd9, 8'h00});
        // good frame with a trailing byte
        send_datagram('{"G", "A", "M", "E", 8'd7, 8'h5A, 8'h5A, 8'h47});
    endtask

    task automatic test_back_to_back();
        idle_pct = 0;
        stall_pct = 0;
        random_traffic(170);
    endtask

    task automatic test_sender_idle();
        idle_pct = 55;
        stall_pct = 0;
        random_traffic(80);
        hold_until_drained();
        random_traffic(80);
    endtask

    task automatic test_receiver_stall();
        idle_pct = 0;
        stall_pct = 55;
        random_traffic(170);
    endtask

    task automatic test_mixed_idle();
        idle_pct = 23;
        stall_pct = 23;
        random_traffic(170);
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed_cases();
        test_back_to_back();
        test_sender_idle();
        test_receiver_stall();
        test_mixed_idle();
        hold_until_drained();
        repeat (10) @(posedge aclk);
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
